FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/dfmt_pkg.sv
// ----------------------------------------------------------------------------
// dfmt_pkg
// Types, constants and helpers shared by the decimal field formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package dfmt_pkg;

  localparam int FIELD_MAX   = 16;
  localparam int IDX_W       = $clog2(FIELD_MAX);
  localparam int LINE_D      = 1 << IDX_W;

  localparam int VALUE_W     = 31;
  localparam int FW_W        = 5;
  localparam int CFG_DATA_W  = 5;
  localparam int CFG_INDEX_W = 1;

  localparam int CONV_STAGES = 4;
  localparam int CONV_BITS   = 32;
  localparam int CONV_STEPS  = CONV_BITS / CONV_STAGES;
  localparam int DIGITS      = 10;
  localparam int BCD_W       = 4 * DIGITS;
  localparam int EXT_D       = (LINE_D > DIGITS) ? LINE_D : DIGITS;

  typedef logic [7:0] char_t;

  localparam char_t      CH_ZERO    = 8'h30;
  localparam char_t      CH_SPACE   = 8'h20;
  localparam char_t      CH_MARK    = 8'h2E;
  localparam logic [3:0] DIGIT_MASK = 4'hF;

  localparam logic [FW_W-1:0] FW_RESET = 5'd11;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FIELD_WIDTH,
    REG_GROUP_MARKS
  } cfg_reg_t;

  typedef struct packed {
    logic [CONV_BITS-1:0] bin;
    logic [BCD_W-1:0]     bcd;
  } conv_t;

  typedef logic [LINE_D-1:0][7:0] line_t;

  typedef struct packed {
    logic [IDX_W-1:0] last_idx;
    logic             group;
  } cfg_t;

  function automatic char_t digit_char(input logic [3:0] d, input logic shown);
    char_t ch;
    ch = shown ? (CH_ZERO + char_t'(d & DIGIT_MASK)) : CH_SPACE;
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: design/dfmt_bcd_stage.sv
// ----------------------------------------------------------------------------
// dfmt_bcd_stage
// One registered stage of the shift-and-add-3 binary to BCD conversion.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dfmt_bcd_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire dfmt_pkg::conv_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output dfmt_pkg::conv_t      out_data
);
  import dfmt_pkg::*;

  conv_t step_next;
  logic  digits_ok;

  always_comb begin
    logic [CONV_BITS-1:0] b;
    logic [BCD_W-1:0]     d;
    b = in_data.bin;
    d = in_data.bcd;
    for (int s = 0; s < CONV_STEPS; s++) begin
      for (int i = 0; i < DIGITS; i++) begin
        if (d[4*i +: 4] >= 4'd5) begin
          d[4*i +: 4] = d[4*i +: 4] + 4'd3;
        end
      end
      d = {d[BCD_W-2:0], b[CONV_BITS-1]};
      b = {b[CONV_BITS-2:0], 1'b0};
    end
    step_next.bin = b;
    step_next.bcd = d;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
      if (in_valid) begin
        out_data <= step_next;
      end
    end
  end

  always_comb begin
    digits_ok = 1'b1;
    for (int i = 0; i < DIGITS; i++) begin
      digits_ok = digits_ok && (out_data.bcd[4*i +: 4] <= 4'd9);
    end
  end

  `ASSERT_IMPLIES(a_digits_decimal, out_valid, digits_ok, "BCD digit out of range")
  `ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_data), "stalled stage changed")

endmodule

`default_nettype wire

FILE: design/dfmt_layout.sv
// ----------------------------------------------------------------------------
// dfmt_layout
// Registered stage that turns BCD digits into a right-aligned character line.
// ----------------------------------------------------------------------------
`default_nettype none

module dfmt_layout (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dfmt_pkg::cfg_t  cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire dfmt_pkg::conv_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output dfmt_pkg::line_t      out_line
);
  import dfmt_pkg::*;

  logic [4*EXT_D-1:0] bcd_ext;
  logic [EXT_D-1:0]   present;
  line_t              line_next;

  assign bcd_ext = (4*EXT_D)'(in_data.bcd);

  always_comb begin
    logic any;
    any = 1'b0;
    for (int i = EXT_D - 1; i >= 0; i--) begin
      any = any || (bcd_ext[4*i +: 4] != 4'd0);
      present[i] = any;
    end
  end

  always_comb begin
    for (int j = 0; j < LINE_D; j++) begin
      if (cfg.group && (j % 4 == 3)) begin
        line_next[j] = present[3*(j/4) + 3] ? CH_MARK : CH_SPACE;
      end else if (cfg.group) begin
        line_next[j] = digit_char(bcd_ext[4*(3*(j/4) + j%4) +: 4],
                                  present[3*(j/4) + j%4] || (j == 0));
      end else begin
        line_next[j] = digit_char(bcd_ext[4*j +: 4], present[j] || (j == 0));
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
      if (in_valid) begin
        out_line <= line_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/dfmt_serializer.sv
// ----------------------------------------------------------------------------
// dfmt_serializer
// Holds one character line and sends it out left to right, one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dfmt_serializer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dfmt_pkg::cfg_t  cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire dfmt_pkg::line_t in_line,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output dfmt_pkg::char_t      character,
  output logic                 last
);
  import dfmt_pkg::*;

  logic             busy;
  logic [IDX_W-1:0] idx;
  line_t            field_store;

  assign last      = (idx == '0);
  assign in_ready  = !busy || (out_ready && last);
  assign out_valid = busy;
  assign character = field_store[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (in_ready) begin
      busy <= in_valid;
      if (in_valid) begin
        field_store <= in_line;
        idx         <= cfg.last_idx;
      end
    end else if (out_ready) begin
      idx <= idx - 1'b1;
    end
  end

  `ASSERT_NEXT(a_stall_holds, busy && !out_ready, busy && $stable(idx), "stall moved the position")
  `ASSERT_NEXT(a_step_down, busy && out_ready && !last, busy && (idx == $past(idx) - 1'b1), "position skipped")
  `ASSERT_IMPLIES(a_within_field, busy, idx <= cfg.last_idx, "position beyond the field")

endmodule

`default_nettype wire

FILE: design/decimal_field_formatter.sv
// ----------------------------------------------------------------------------
// decimal_field_formatter
// Formats a binary value as a right-aligned decimal ASCII field.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    value[30:0]
//   output    out_valid / out_ready  character[7:0], last
//   config    cfg_write              cfg_index[0], cfg_data[4:0]
//
// After a transaction is accepted, it passes four conversion stages, one layout
// stage and the output register before the first character leaves.
// Each value occupies the output for field_width - 1 characters (field_width
// clamped to 2 .. 16), so the output port sets the sustained rate.
// Up to six values are in flight; the input takes one per cycle until full.
// A stall on the output holds each full stage that cannot pass its data on;
// nothing is dropped or repeated. Reset clears the valid bits and restores
// field_width 11 and no grouping.
`default_nettype none

module decimal_field_formatter (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [dfmt_pkg::VALUE_W-1:0]       value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [7:0]                              character,
  output logic                                    last,
  input  wire logic                               cfg_write,
  input  wire logic [dfmt_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [dfmt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dfmt_pkg::*;

  logic [FW_W-1:0]  field_width;
  logic             group_marks;
  logic [IDX_W:0]   fw_eff;
  cfg_t             cfg;

  wire  [CONV_STAGES:0] conv_valid;
  wire  [CONV_STAGES:0] conv_ready;
  wire  conv_t          conv_data [CONV_STAGES+1];

  logic  line_valid;
  logic  line_ready;
  line_t line_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_width <= FW_RESET;
      group_marks <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_FIELD_WIDTH: field_width <= cfg_data[FW_W-1:0];
        REG_GROUP_MARKS: group_marks <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(field_width) > FIELD_MAX) begin
      fw_eff = (IDX_W+1)'(FIELD_MAX);
    end else if (field_width < FW_W'(2)) begin
      fw_eff = (IDX_W+1)'(2);
    end else begin
      fw_eff = (IDX_W+1)'(field_width);
    end
    cfg.last_idx = IDX_W'(fw_eff - (IDX_W+1)'(2));
    cfg.group    = group_marks;
  end

  assign conv_valid[0] = in_valid;
  assign in_ready      = conv_ready[0];
  assign conv_data[0]  = '{bin: CONV_BITS'(value), bcd: '0};

  for (genvar g = 0; g < CONV_STAGES; g++) begin : g_conv
    dfmt_bcd_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (conv_valid[g]),
      .in_ready  (conv_ready[g]),
      .in_data   (conv_data[g]),
      .out_valid (conv_valid[g+1]),
      .out_ready (conv_ready[g+1]),
      .out_data  (conv_data[g+1])
    );
  end

  dfmt_layout u_layout (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (conv_valid[CONV_STAGES]),
    .in_ready  (conv_ready[CONV_STAGES]),
    .in_data   (conv_data[CONV_STAGES]),
    .out_valid (line_valid),
    .out_ready (line_ready),
    .out_line  (line_data)
  );

  dfmt_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (line_valid),
    .in_ready  (line_ready),
    .in_line   (line_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
  );

endmodule

`default_nettype wire
